@@ sv/tgf_pkg.sv @@
package tgf_pkg;

    // line sizing
    localparam int MAX_WINDOW = 16;
    localparam int LINE_DEPTH = MAX_WINDOW + 1;
    localparam int FILL_W     = $clog2(LINE_DEPTH + 1);
    localparam int MARK_IW    = $clog2(LINE_DEPTH);
    localparam int RAM_AW     = $clog2(LINE_DEPTH);
    localparam int RAM_DEPTH  = 1 << RAM_AW;

    // point fields
    localparam int LAT_W  = 28;
    localparam int LNG_W  = 29;
    localparam int SEC_W  = 32;
    localparam int PT_W   = LAT_W + LNG_W + SEC_W;
    localparam int DATA_W = ((PT_W + 7) / 8) * 8;

    // distance arithmetic
    localparam int COORD_W = 30;
    localparam int MAG_W   = 30;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int DIST_W  = PROD_W + 1;

    // configuration
    localparam int DECIM_W = 16;
    localparam int WCNT_W  = 5;
    localparam int RAD_W   = 29;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 29;

    localparam logic [DECIM_W-1:0] DECIM_MAX     = '1;
    localparam logic [WCNT_W-1:0]  WCNT_RESET    = WCNT_W'(10);
    localparam logic [RAD_W-1:0]   RADIUS_RESET  = RAD_W'(40);

    typedef enum logic [CFG_IW-1:0] {
        CFG_DECIM_PERIOD  = 2'd0,
        CFG_WINDOW_COUNT  = 2'd1,
        CFG_WINDOW_RADIUS = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        V_KEEP_DECIM   = 2'd0,
        V_KEEP_WINDOW  = 2'd1,
        V_DROP_MARKED  = 2'd2,
        V_DROP_DECIM   = 2'd3
    } t_verdict;

    // operands for the shared squared-distance unit
    typedef struct packed {
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
    } t_mul_req;

endpackage

@@ sv/tgf_ram.sv @@
module tgf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/tgf_mul.sv @@
module tgf_mul import tgf_pkg::*; (
    input  logic              i_clk,
    input  t_mul_req          i_req,
    output logic [PROD_W-1:0] o_prod
);

    logic signed [COORD_W:0] diff;
    logic signed [COORD_W:0] diff_abs;
    logic [MAG_W-1:0]        mag;
    logic [PROD_W-1:0]       r_prod;

    // absolute difference of the two operands
    always_comb begin
        diff     = {i_req.a[COORD_W-1], i_req.a} - {i_req.b[COORD_W-1], i_req.b};
        diff_abs = diff[COORD_W] ? -diff : diff;
        mag      = diff_abs[MAG_W-1:0];
    end

    // squared magnitude, registered
    always_ff @(posedge i_clk) begin
        r_prod <= mag * mag;
    end

    assign o_prod = r_prod;

endmodule

@@ sv/gps_track_thinning_filter.sv @@
// GPS track thinning filter. Each accepted fix is appended to a line of up to
// seventeen points kept in a small ring RAM. A point is judged once window_count
// later points wait behind it, or when a beat with tlast set flushes the line;
// every judged point leaves as one output beat with its verdict in tuser and
// tlast set on the last verdict of a flush. Judging runs through one shared
// squared-distance unit (subtract, absolute value, 30x30 multiply) under a
// sequencer: S_CHECK and S_HEAD read the head and square the radius, each
// follower compared passes S_FADDR, S_FLAT, S_FLNG and S_FCMP, a closing S_FADDR
// ends a walk that reaches the window or the end of the line (none when a
// follower falls outside the radius), and S_EMIT emits; a point already marked
// goes from S_HEAD straight to S_EMIT. One input beat is accepted in S_IDLE and
// ends with a closing S_CHECK, after the states of every point it releases, the
// followers compared being at most window_count, capped at sixteen. The reset
// window is ten. s_axis_tready is high only while the sequencer is idle; an
// output register lets the sequencer run on while the last result waits, and
// emit stalls while that register holds a beat that is not yet taken.
// Configuration writes belong in idle time.
module gps_track_thinning_filter import tgf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    // input fixes
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // lat_udeg, lng_udeg, fix_seconds, zero pad
    input  logic              s_axis_tlast,   // final_point
    // judged points
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // out_lat, out_lng, out_seconds, zero pad
    output logic [1:0]        m_axis_tuser,   // verdict
    output logic              m_axis_tlast    // last_of_run
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_HEAD  = 8'b0000_0100,
        S_FADDR = 8'b0000_1000,
        S_FLAT  = 8'b0001_0000,
        S_FLNG  = 8'b0010_0000,
        S_FCMP  = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    t_state                r_state;
    logic [RAM_AW-1:0]     r_head;
    logic [FILL_W-1:0]     r_fill;
    logic                  r_fin;
    logic [LINE_DEPTH-1:0] r_marks;
    logic [DECIM_W-1:0]    r_decim;
    logic [FILL_W-1:0]     r_i;
    logic                  r_same;
    logic                  r_win;
    logic [PROD_W-1:0]     r_r2;
    logic [PROD_W-1:0]     r_acc;
    logic [PT_W-1:0]       r_head_pt;

    logic [DECIM_W-1:0]    r_decim_period;
    logic [WCNT_W-1:0]     r_window_count;
    logic [RAD_W-1:0]      r_window_radius;

    logic                  r_out_valid;
    logic [PT_W-1:0]       r_out_pt;
    t_verdict              r_out_verdict;
    logic                  r_out_last;

    logic [FILL_W-1:0]     w_eff;
    logic                  judge_need;
    logic [FILL_W-1:0]     i_next;
    logic [MARK_IW-1:0]    mark_idx;
    logic                  ram_we;
    logic [RAM_AW-1:0]     ram_waddr;
    logic                  ram_re;
    logic [RAM_AW-1:0]     ram_raddr;
    logic [PT_W-1:0]       ram_rdata;
    t_mul_req              mul_req;
    logic [PROD_W-1:0]     mul_prod;
    logic [DIST_W-1:0]     dist_sum;
    logic                  dist_zero;
    logic                  dist_out;
    logic                  out_free;
    logic [DECIM_W-1:0]    decim_inc;
    logic [DECIM_W-1:0]    n_decim;
    t_verdict              n_verdict;
    logic [LINE_DEPTH-1:0] win_mask;
    logic [LINE_DEPTH-1:0] n_marks;

    // effective window and judge condition
    always_comb begin
        w_eff      = (r_window_count > MAX_WINDOW) ? FILL_W'(MAX_WINDOW)
                                                   : FILL_W'(r_window_count);
        judge_need = r_fin ? (r_fill != '0) : (r_fill > w_eff);
        i_next     = r_i + 1'b1;
        mark_idx   = i_next[MARK_IW-1:0];
    end

    // ring RAM access
    always_comb begin
        ram_we    = (r_state == S_IDLE) && s_axis_tvalid;
        ram_waddr = r_head + r_fill[RAM_AW-1:0];
        ram_re    = 1'b0;
        ram_raddr = r_head;
        if (r_state == S_CHECK) begin
            ram_re = judge_need;
        end else if (r_state == S_FADDR) begin
            ram_re    = 1'b1;
            ram_raddr = r_head + i_next[RAM_AW-1:0];
        end
    end

    tgf_ram #(
        .WIDTH (PT_W),
        .DEPTH (RAM_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (s_axis_tdata[PT_W-1:0]),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // operand select for the shared distance unit
    always_comb begin
        mul_req.a = '0;
        mul_req.b = '0;
        case (r_state)
            S_CHECK: begin
                mul_req.a = COORD_W'(r_window_radius);
            end
            S_FLAT: begin
                mul_req.a = COORD_W'($signed(r_head_pt[LAT_W-1:0]));
                mul_req.b = COORD_W'($signed(ram_rdata[LAT_W-1:0]));
            end
            S_FLNG: begin
                mul_req.a = COORD_W'($signed(r_head_pt[LAT_W+LNG_W-1:LAT_W]));
                mul_req.b = COORD_W'($signed(ram_rdata[LAT_W+LNG_W-1:LAT_W]));
            end
            default: begin
                mul_req.a = '0;
            end
        endcase
    end

    tgf_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    // distance compare
    always_comb begin
        dist_sum  = DIST_W'(r_acc) + DIST_W'(mul_prod);
        dist_zero = (dist_sum == '0);
        dist_out  = dist_sum > DIST_W'(r_r2);
    end

    // verdict, decimation and window marks of the head
    always_comb begin
        out_free  = !r_out_valid || m_axis_tready;
        decim_inc = (r_decim == DECIM_MAX) ? r_decim : r_decim + 1'b1;
        if (r_marks[0]) begin
            n_verdict = V_DROP_MARKED;
            n_decim   = DECIM_MAX;
        end else if (r_win) begin
            n_verdict = V_KEEP_WINDOW;
            n_decim   = '0;
        end else if (decim_inc >= r_decim_period) begin
            n_verdict = V_KEEP_DECIM;
            n_decim   = '0;
        end else begin
            n_verdict = V_DROP_DECIM;
            n_decim   = decim_inc;
        end
        for (int k = 0; k < LINE_DEPTH; k++) begin
            win_mask[k] = r_win && (k >= 1) && (k <= int'(w_eff));
        end
        n_marks = (r_marks | win_mask) >> 1;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_fill  <= '0;
            r_fin   <= 1'b0;
            r_marks <= '0;
            r_decim <= '0;
            r_i     <= '0;
            r_same  <= 1'b0;
            r_win   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_fill  <= r_fill + 1'b1;
                        r_fin   <= s_axis_tlast;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (judge_need) begin
                        r_state <= S_HEAD;
                    end else begin
                        if (r_fin) begin
                            r_marks <= '0;
                            r_decim <= '0;
                            r_fin   <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_HEAD: begin
                    r_i    <= '0;
                    r_same <= 1'b1;
                    r_win  <= 1'b0;
                    r_state <= r_marks[0] ? S_EMIT : S_FADDR;
                end
                S_FADDR: begin
                    if ((r_i == w_eff) || (i_next >= r_fill)) begin
                        r_win   <= (r_i == w_eff);
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_FLAT;
                    end
                end
                S_FLAT: begin
                    r_state <= S_FLNG;
                end
                S_FLNG: begin
                    r_state <= S_FCMP;
                end
                S_FCMP: begin
                    // leading run of identical positions gets marked
                    if (r_same && dist_zero) begin
                        r_marks[mark_idx] <= 1'b1;
                    end
                    r_same <= r_same && dist_zero;
                    if (dist_out) begin
                        r_win   <= 1'b0;
                        r_state <= S_EMIT;
                    end else begin
                        r_i     <= i_next;
                        r_state <= S_FADDR;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_decim <= n_decim;
                        r_marks <= n_marks;
                        r_head  <= r_head + 1'b1;
                        r_fill  <= r_fill - 1'b1;
                        r_state <= S_CHECK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // head point, radius squared and partial sum
    always_ff @(posedge i_clk) begin
        if (r_state == S_HEAD) begin
            r_head_pt <= ram_rdata;
            r_r2      <= mul_prod;
        end
        if (r_state == S_FLNG) begin
            r_acc <= mul_prod;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decim_period  <= '0;
            r_window_count  <= WCNT_RESET;
            r_window_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_DECIM_PERIOD:  r_decim_period  <= i_cfg_data[DECIM_W-1:0];
                CFG_WINDOW_COUNT:  r_window_count  <= i_cfg_data[WCNT_W-1:0];
                CFG_WINDOW_RADIUS: r_window_radius <= i_cfg_data[RAD_W-1:0];
                default: begin
                    r_window_radius <= r_window_radius;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && out_free) begin
            r_out_pt      <= r_head_pt;
            r_out_verdict <= n_verdict;
            r_out_last    <= r_fin && (r_fill == FILL_W'(1));
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DATA_W'(r_out_pt);
    assign m_axis_tuser  = r_out_verdict;
    assign m_axis_tlast  = r_out_last;

endmodule

@@ sv/tgf_checker.sv @@
module tgf_checker import tgf_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic [1:0]        m_axis_tuser,
    input logic              m_axis_tlast
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // an accepted fix starts the sequencer, input closes
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still ready after accepting a fix");

    // verdicts appear only while the sequencer is busy
    a_result_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !s_axis_tready)
        else $error("new verdict appeared while idle");

    // pad bits of the output beat stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[DATA_W-1:PT_W] == '0))
        else $error("output pad bits not zero");

endmodule

bind gps_track_thinning_filter tgf_checker u_tgf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
